/* hdl/sprite_rle_palette_decoder_macros.svh */
// Assertion macros shared by the sprite decoder RTL.
`ifndef SPRITE_RLE_PALETTE_DECODER_MACROS_SVH
`define SPRITE_RLE_PALETTE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SRPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite decoder check failed");

// Next-cycle implication, disabled while reset is high.
`define SRPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite decoder check failed");

`endif

/* hdl/srpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srpd_pkg;

   // Palette store geometry.
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

   // Queue between the decode front and the palette back end.
   localparam int JQ_DEPTH = 4;
   localparam int JQ_AW    = $clog2(JQ_DEPTH);
   localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

   // Result queue at the output.
   localparam int OQ_DEPTH = 2;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   // Control register indexes.
   localparam logic [2:0] CSR_EXTENDED_MODE    = 3'd0;
   localparam logic [2:0] CSR_INDEX_ONLY       = 3'd1;
   localparam logic [2:0] CSR_BACKGROUND_COLOR = 3'd2;
   localparam logic [2:0] CSR_PALETTE_COUNT    = 3'd3;
   localparam logic [2:0] CSR_ROW_WIDTH        = 3'd4;

   // Reset values of the control registers.
   localparam logic [31:0] BACKGROUND_RESET    = 32'h00ffff00;
   localparam logic [8:0]  PALETTE_COUNT_RESET = 9'd256;

   // Input command codes.
   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic {
      JOB_RUN,
      JOB_WRITE
   } job_kind_type;

   typedef struct packed {
      logic        extended_mode;
      logic        index_only;
      logic [31:0] background_color;
      logic [8:0]  palette_count;
      logic [7:0]  row_width;
   } cfg_type;

   // One unit of work handed from the front to the back end.
   typedef struct packed {
      job_kind_type kind;
      logic         use_mem;
      logic         keep_upper;
      logic [7:0]   index;
      logic [31:0]  data;
      logic [6:0]   run_length;
      logic         transparent;
      logic         row_end;
      logic         bad;
   } job_type;

   typedef struct packed {
      logic [31:0] color;
      logic [6:0]  run_length;
      logic        is_transparent;
      logic        row_end;
      logic        bad_index;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/sprite_rle_palette_decoder.sv */
// Sprite row RLE decoder: takes one coded byte or palette write per cycle while
// full is low on the push/full side and returns one word per run (colour, length,
// transparent, row end, bad index) on the empty/pop side. The sustained rate is
// one word per cycle while pop keeps up, set by the single-port palette memory in
// the back end, which serves one write or one read each cycle. A result passes
// through the job queue, the read stage and the result queue before it shows on
// the rsp_ ports. Palette writes and data bytes are handled in arrival order, so a
// palette entry written before a run's index byte is seen by that run. Control
// registers may be written only while no result is pending; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "sprite_rle_palette_decoder_macros.svh"

module sprite_rle_palette_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [7:0]  req_palette_index,
   input  wire logic [31:0] req_palette_entry,
   output      logic        empty,
   input  wire logic        pop,
   output      logic [31:0] rsp_color,
   output      logic [6:0]  rsp_run_length,
   output      logic        rsp_is_transparent,
   output      logic        rsp_row_end,
   output      logic        rsp_bad_index,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   srpd_pkg::cfg_type cfg_ff;
   srpd_pkg::job_type front_job;
   srpd_pkg::job_type head_job;
   srpd_pkg::rsp_type rsp;
   logic              accept;
   logic              job_push;
   logic              jq_full;
   logic              jq_empty;
   logic              jq_pop;

   // Control registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extended_mode    <= 1'b0;
         cfg_ff.index_only       <= 1'b0;
         cfg_ff.background_color <= srpd_pkg::BACKGROUND_RESET;
         cfg_ff.palette_count    <= srpd_pkg::PALETTE_COUNT_RESET;
         cfg_ff.row_width        <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srpd_pkg::CSR_EXTENDED_MODE:    cfg_ff.extended_mode    <= csr_data[0];
            srpd_pkg::CSR_INDEX_ONLY:       cfg_ff.index_only       <= csr_data[0];
            srpd_pkg::CSR_BACKGROUND_COLOR: cfg_ff.background_color <= csr_data;
            srpd_pkg::CSR_PALETTE_COUNT:    cfg_ff.palette_count    <= csr_data[8:0];
            srpd_pkg::CSR_ROW_WIDTH:        cfg_ff.row_width        <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input word is taken whenever the job queue has room.
   assign full   = jq_full;
   assign accept = push && !jq_full;

   srpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .command       (req_command),
      .byte_value    (req_byte_value),
      .palette_index (req_palette_index),
      .palette_entry (req_palette_entry),
      .job_push      (job_push),
      .job           (front_job)
   );

   srpd_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (jq_full),
      .pop      (jq_pop),
      .head_job (head_job),
      .empty    (jq_empty)
   );

   srpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_empty (jq_empty),
      .job_pop   (jq_pop),
      .rsp       (rsp),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   // Result fields.
   assign rsp_color          = rsp.color;
   assign rsp_run_length     = rsp.run_length;
   assign rsp_is_transparent = rsp.is_transparent;
   assign rsp_row_end        = rsp.row_end;
   assign rsp_bad_index      = rsp.bad_index;

   // A flagged index always reports a zero colour.
   `SRPD_ASSERT_IMPLY(a_bad_zero_color, clock, reset, !empty && rsp_bad_index, rsp_color == 32'h0)
   // Background runs never carry an index error.
   `SRPD_ASSERT_IMPLY(a_transp_not_bad, clock, reset, !empty && rsp_is_transparent, !rsp_bad_index)
   // Outside extended mode colours are 24 bits wide.
   `SRPD_ASSERT_IMPLY(a_color_24bit, clock, reset, !empty && !cfg_ff.extended_mode, rsp_color[31:24] == 8'h00)
   // A full job queue stays full until the back end takes a job.
   `SRPD_ASSERT_NEXT(a_jq_hold_full, clock, reset, jq_full && !jq_pop, jq_full)

endmodule

`default_nettype wire

/* hdl/srpd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire srpd_pkg::cfg_type cfg,
   input  wire logic             accept,
   input  wire logic             command,
   input  wire logic [7:0]       byte_value,
   input  wire logic [7:0]       palette_index,
   input  wire logic [31:0]      palette_entry,
   output      logic             job_push,
   output      srpd_pkg::job_type job
);

   typedef enum logic [1:0] {
      PH_CTRL,
      PH_SOLID,
      PH_LIT,
      PH_UNUSED
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [6:0]  pending_ff, pending_in;
   logic [8:0]  column_ff, column_in;

   logic [7:0]  lk_index;
   logic        lk_bad;
   logic [6:0]  pending_dec;
   logic [6:0]  adv_count;
   logic        adv_may_end;
   logic [8:0]  col_sum;
   logic        adv_end;
   logic [31:0] bg_fit;

   // Palette index after the optional decrement, and its range check.
   always_comb begin
      lk_index = cfg.extended_mode ? (byte_value - 8'd1) : byte_value;
      lk_bad   = cfg.extended_mode && ({1'b0, lk_index} >= cfg.palette_count);
      bg_fit   = cfg.extended_mode ? cfg.background_color
                                   : {8'h00, cfg.background_color[23:0]};
      pending_dec = pending_ff - 7'd1;
   end

   // Pixel count added to the column, and whether this run may close the row.
   always_comb begin
      case (phase_ff)
         PH_SOLID: begin
            adv_count   = pending_ff;
            adv_may_end = 1'b1;
         end
         PH_LIT: begin
            adv_count   = 7'd1;
            adv_may_end = (pending_dec == 7'd0);
         end
         default: begin
            adv_count   = byte_value[6:0];
            adv_may_end = 1'b1;
         end
      endcase
      col_sum = column_ff + {2'b00, adv_count};
      adv_end = adv_may_end && (col_sum >= {1'b0, cfg.row_width});
   end

   // Decode of one word: next state and the job it hands to the back end.
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      column_in  = column_ff;
      job_push   = 1'b0;

      job.kind        = srpd_pkg::JOB_RUN;
      job.use_mem     = !lk_bad && !cfg.index_only;
      job.keep_upper  = cfg.extended_mode;
      job.index       = lk_index;
      job.data        = (lk_bad || !cfg.index_only) ? 32'h0
                                                    : {16'h00ff, 8'h00, lk_index};
      job.run_length  = adv_count;
      job.transparent = 1'b0;
      job.row_end     = adv_end;
      job.bad         = lk_bad;

      if (command == srpd_pkg::CMD_WRITE) begin
         job.kind    = srpd_pkg::JOB_WRITE;
         job.use_mem = 1'b0;
         job.index   = palette_index;
         job.data    = palette_entry;
         job_push    = accept;
      end else begin
         case (phase_ff)
            PH_SOLID: begin
               job_push   = accept;
               column_in  = adv_end ? 9'd0 : col_sum;
               phase_in   = PH_CTRL;
               pending_in = 7'd0;
            end
            PH_LIT: begin
               job_push   = accept;
               column_in  = adv_end ? 9'd0 : col_sum;
               pending_in = pending_dec;
               if (pending_dec == 7'd0) begin
                  phase_in = PH_CTRL;
               end
            end
            default: begin
               if (byte_value[7]) begin
                  // Transparent run of background pixels.
                  job_push        = accept;
                  job.use_mem     = 1'b0;
                  job.data        = bg_fit;
                  job.transparent = 1'b1;
                  job.bad         = 1'b0;
                  column_in       = adv_end ? 9'd0 : col_sum;
                  phase_in        = PH_CTRL;
               end else if (byte_value[6]) begin
                  pending_in = {1'b0, byte_value[5:0]};
                  phase_in   = PH_SOLID;
               end else begin
                  pending_in = {1'b0, byte_value[5:0]};
                  phase_in   = (byte_value[5:0] != 6'd0) ? PH_LIT : PH_CTRL;
               end
            end
         endcase
      end
   end

   // Decode state advances only on accepted words.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CTRL;
         pending_ff <= 7'd0;
         column_ff  <= 9'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         column_ff  <= column_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/srpd_job_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpd_job_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire srpd_pkg::job_type push_job,
   output      logic              full,
   input  wire logic              pop,
   output      srpd_pkg::job_type head_job,
   output      logic              empty
);

   srpd_pkg::job_type                 store_ff [srpd_pkg::JQ_DEPTH];
   logic [srpd_pkg::JQ_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [srpd_pkg::JQ_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [srpd_pkg::JQ_CW-1:0]        count_ff, count_in;

   // Occupancy flags and the head entry.
   always_comb begin
      full     = (count_ff == srpd_pkg::JQ_CW'(srpd_pkg::JQ_DEPTH));
      empty    = (count_ff == '0);
      head_job = store_ff[rd_ptr_ff];
   end

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* hdl/srpd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire srpd_pkg::job_type job,
   input  wire logic              job_empty,
   output      logic              job_pop,
   output      srpd_pkg::rsp_type rsp,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop
);

   logic [31:0]                palette_mem [srpd_pkg::PALETTE_DEPTH];
   logic [srpd_pkg::PAL_AW-1:0] job_addr;
   logic                        job_in_range;

   logic                        s1_valid_ff, s1_valid_in;
   srpd_pkg::job_type           s1_job_ff;
   logic                        s1_in_range_ff;
   logic [31:0]                 rd_data_ff;
   logic                        s1_adv;
   logic                        s1_load;
   srpd_pkg::rsp_type           s1_rsp;

   srpd_pkg::rsp_type           oq_ff [srpd_pkg::OQ_DEPTH];
   logic [srpd_pkg::OQ_AW-1:0]  oq_wr_ptr_ff, oq_rd_ptr_ff;
   logic [srpd_pkg::OQ_CW-1:0]  oq_count_ff, oq_count_in;
   logic                        oq_pop;

   // Job address and its range against the palette depth.
   always_comb begin
      job_addr     = job.index[srpd_pkg::PAL_AW-1:0];
      job_in_range = ({1'b0, job.index} < 9'(srpd_pkg::PALETTE_DEPTH));
   end

   // Handshake between the job queue, the read stage and the result queue.
   always_comb begin
      oq_pop      = rsp_pop && !rsp_empty;
      s1_adv      = s1_valid_ff && (oq_count_ff != srpd_pkg::OQ_CW'(srpd_pkg::OQ_DEPTH));
      s1_load     = !job_empty && (job.kind == srpd_pkg::JOB_RUN)
                    && (!s1_valid_ff || s1_adv);
      job_pop     = s1_load || (!job_empty && (job.kind == srpd_pkg::JOB_WRITE));
      s1_valid_in = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   // Palette store: writes from write jobs, registered reads for run jobs.
   always_ff @(posedge clock) begin
      if (job_pop && (job.kind == srpd_pkg::JOB_WRITE) && job_in_range) begin
         palette_mem[job_addr] <= job.data;
      end
      if (s1_load) begin
         rd_data_ff <= palette_mem[job_addr];
      end
   end

   // Read stage holding the job while its palette word is fetched.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_job_ff      <= job;
         s1_in_range_ff <= job_in_range;
      end
   end

   // Final colour selection for the run.
   always_comb begin
      s1_rsp.color = s1_job_ff.data;
      if (s1_job_ff.use_mem) begin
         if (!s1_in_range_ff) begin
            s1_rsp.color = 32'h0;
         end else if (s1_job_ff.keep_upper) begin
            s1_rsp.color = rd_data_ff;
         end else begin
            s1_rsp.color = {8'h00, rd_data_ff[23:0]};
         end
      end
      s1_rsp.run_length     = s1_job_ff.run_length;
      s1_rsp.is_transparent = s1_job_ff.transparent;
      s1_rsp.row_end        = s1_job_ff.row_end;
      s1_rsp.bad_index      = s1_job_ff.bad;
   end

   // Result queue decoupling the read stage from the consumer.
   always_comb begin
      oq_count_in = oq_count_ff;
      if (s1_adv && !oq_pop) begin
         oq_count_in = oq_count_ff + 1'b1;
      end else if (oq_pop && !s1_adv) begin
         oq_count_in = oq_count_ff - 1'b1;
      end
      rsp_empty = (oq_count_ff == '0);
      rsp       = oq_ff[oq_rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         if (s1_adv) begin
            oq_wr_ptr_ff <= oq_wr_ptr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ptr_ff <= oq_rd_ptr_ff + 1'b1;
         end
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         oq_ff[oq_wr_ptr_ff] <= s1_rsp;
      end
   end

endmodule

`default_nettype wire

/* bench/tb_sprite_rle_palette_decoder.sv */
`timescale 1ns / 1ps

module tb_sprite_rle_palette_decoder;

   localparam int          STALL_LIMIT = 4000;
   localparam int          SETTLE_CYCLES = 8;
   localparam logic [31:0] INDEX_TAG = 32'h00ff_0000;

   typedef enum logic [1:0] {
      DEC_CTRL,
      DEC_SOLID,
      DEC_LIT
   } dec_state_type;

   // Shadow of the decoder: registers, decode state and palette, plus the
   // runs that the block still owes us in arrival order.
   class run_scoreboard;
      logic                  ext_mode;
      logic                  idx_only;
      logic [31:0]           bg_color;
      logic [8:0]            pal_count;
      logic [7:0]            row_width;
      dec_state_type         dec_state;
      logic [6:0]            pend;
      logic [8:0]            column;
      logic [31:0]           pal_mem [srpd_pkg::PALETTE_DEPTH];
      bit                    pal_set [srpd_pkg::PALETTE_DEPTH];
      srpd_pkg::rsp_type     runs_due [$];
      int                    errors;

      function new();
         ext_mode  = 1'b0;
         idx_only  = 1'b0;
         bg_color  = srpd_pkg::BACKGROUND_RESET;
         pal_count = srpd_pkg::PALETTE_COUNT_RESET;
         row_width = 8'd0;
         dec_state = DEC_CTRL;
         pend      = 7'd0;
         column    = 9'd0;
         errors    = 0;
         foreach (pal_set[i]) pal_set[i] = 1'b0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [31:0] d);
         case (idx)
            srpd_pkg::CSR_EXTENDED_MODE:    ext_mode  = d[0];
            srpd_pkg::CSR_INDEX_ONLY:       idx_only  = d[0];
            srpd_pkg::CSR_BACKGROUND_COLOR: bg_color  = d;
            srpd_pkg::CSR_PALETTE_COUNT:    pal_count = d[8:0];
            srpd_pkg::CSR_ROW_WIDTH:        row_width = d[7:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] fit_color(input logic [31:0] c);
         return ext_mode ? c : {8'd0, c[23:0]};
      endfunction

      // Palette lookup of an index byte, with the extended-mode decrement and
      // range check.
      function void color_of(input logic [7:0] b, output logic [31:0] c,
                             output logic bad);
         logic [7:0] idx;
         idx = ext_mode ? b - 8'd1 : b;
         bad = 1'b0;
         c   = 32'd0;
         if (ext_mode && {1'b0, idx} >= pal_count) begin
            bad = 1'b1;
            return;
         end
         if (idx_only)
            c = fit_color(INDEX_TAG | {24'd0, idx});
         else if (idx < srpd_pkg::PALETTE_DEPTH)
            c = fit_color(pal_mem[idx]);
      endfunction

      // Moves the column on and reports whether the row ends here.
      function logic step_column(input logic [6:0] n, input logic may_end);
         column = column + 9'(n);
         if (may_end && column >= {1'b0, row_width}) begin
            column = 9'd0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // True when the next data byte would read a palette entry never written.
      function bit needs_fill(input logic [7:0] b, output logic [7:0] idx);
         idx = ext_mode ? b - 8'd1 : b;
         if (dec_state != DEC_SOLID && dec_state != DEC_LIT) return 1'b0;
         if (idx_only) return 1'b0;
         if (ext_mode && {1'b0, idx} >= pal_count) return 1'b0;
         return (idx < srpd_pkg::PALETTE_DEPTH) && !pal_set[idx];
      endfunction

      function void note_word(input logic cmd, input logic [7:0] b,
                              input logic [7:0] pi, input logic [31:0] pe);
         srpd_pkg::rsp_type r;
         logic [31:0]       c;
         logic              bad;
         r = '0;
         if (cmd == srpd_pkg::CMD_WRITE) begin
            if (pi < srpd_pkg::PALETTE_DEPTH) begin
               pal_mem[pi] = pe;
               pal_set[pi] = 1'b1;
            end
            return;
         end
         case (dec_state)
            DEC_SOLID: begin
               color_of(b, c, bad);
               r.color      = c;
               r.bad_index  = bad;
               r.run_length = pend;
               r.row_end    = step_column(pend, 1'b1);
               dec_state    = DEC_CTRL;
               pend         = 7'd0;
               runs_due.push_back(r);
            end
            DEC_LIT: begin
               color_of(b, c, bad);
               pend         = pend - 7'd1;
               r.color      = c;
               r.bad_index  = bad;
               r.run_length = 7'd1;
               r.row_end    = step_column(7'd1, pend == 7'd0);
               if (pend == 7'd0) dec_state = DEC_CTRL;
               runs_due.push_back(r);
            end
            default: begin
               // Control byte: transparent, solid or literal group.
               if (b[7]) begin
                  r.color          = fit_color(bg_color);
                  r.run_length     = b[6:0];
                  r.is_transparent = 1'b1;
                  r.row_end        = step_column(b[6:0], 1'b1);
                  dec_state        = DEC_CTRL;
                  runs_due.push_back(r);
               end else if (b[6]) begin
                  pend      = {1'b0, b[5:0]};
                  dec_state = DEC_SOLID;
               end else begin
                  pend      = {1'b0, b[5:0]};
                  dec_state = (pend != 7'd0) ? DEC_LIT : DEC_CTRL;
               end
            end
         endcase
      endfunction

      function void flag(input string what, input srpd_pkg::rsp_type want,
                         input srpd_pkg::rsp_type got);
         errors++;
         if (errors <= 10)
            $display("ERROR %s: expected color %h len %0d tr %b end %b bad %b, %s",
                     what, want.color, want.run_length, want.is_transparent,
                     want.row_end, want.bad_index,
                     $sformatf("got color %h len %0d tr %b end %b bad %b",
                               got.color, got.run_length, got.is_transparent,
                               got.row_end, got.bad_index));
      endfunction

      function void check_word(input srpd_pkg::rsp_type got);
         srpd_pkg::rsp_type want;
         if (runs_due.size() == 0) begin
            flag("word with none expected", '0, got);
            return;
         end
         want = runs_due.pop_front();
         if (got.color !== want.color || got.run_length !== want.run_length ||
             got.is_transparent !== want.is_transparent ||
             got.row_end !== want.row_end || got.bad_index !== want.bad_index)
            flag("field mismatch", want, got);
      endfunction

      function int pending();
         return runs_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_command = srpd_pkg::CMD_DATA;
   logic [7:0]  req_byte_value = 8'd0;
   logic [7:0]  req_palette_index = 8'd0;
   logic [31:0] req_palette_entry = 32'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_color;
   logic [6:0]  rsp_run_length;
   logic        rsp_is_transparent;
   logic        rsp_row_end;
   logic        rsp_bad_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = srpd_pkg::CSR_EXTENDED_MODE;
   logic [31:0] csr_data = 32'd0;

   srpd_pkg::rsp_type rsp_seen;
   run_scoreboard     sb = new();
   int                burst_left = 0;
   int                words_sent = 0;
   int                idle_cycles = 0;
   int                pop_mode = 0;
   int                pop_mode_left = 0;

   assign rsp_seen = {rsp_color, rsp_run_length, rsp_is_transparent, rsp_row_end,
                      rsp_bad_index};

   sprite_rle_palette_decoder u_top (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_command        (req_command),
      .req_byte_value     (req_byte_value),
      .req_palette_index  (req_palette_index),
      .req_palette_entry  (req_palette_entry),
      .empty              (empty),
      .pop                (pop),
      .rsp_color          (rsp_color),
      .rsp_run_length     (rsp_run_length),
      .rsp_is_transparent (rsp_is_transparent),
      .rsp_row_end        (rsp_row_end),
      .rsp_bad_index      (rsp_bad_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: switches between always ready, coin-flip and sparse pops.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop_mode_left == 0) begin
            pop_mode      <= $urandom_range(0, 2);
            pop_mode_left <= $urandom_range(20, 150);
         end else begin
            pop_mode_left <= pop_mode_left - 1;
         end
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Every word taken from the result side is checked against the oldest run.
   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_word(rsp_seen);
   end

   // Watchdog on cycles where no word moves on any channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Offers one word, with sender bursts and gaps, and records it on accept.
   task automatic send_word(input logic cmd, input logic [7:0] b,
                            input logic [7:0] pi, input logic [31:0] pe);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      push              <= 1'b1;
      req_command       <= cmd;
      req_byte_value    <= b;
      req_palette_index <= pi;
      req_palette_entry <= pe;
      do @(posedge clock); while (full);
      sb.note_word(cmd, b, pi, pe);
      words_sent++;
   endtask

   task automatic send_palette(input logic [7:0] idx, input logic [31:0] entry);
      send_word(srpd_pkg::CMD_WRITE, 8'($urandom), idx, entry);
   endtask

   // Data byte; an index byte that would hit an unwritten entry gets that
   // entry written first.
   task automatic send_data(input logic [7:0] b);
      logic [7:0] fill_idx;
      if (sb.needs_fill(b, fill_idx)) send_palette(fill_idx, $urandom);
      send_word(srpd_pkg::CMD_DATA, b, 8'($urandom), $urandom);
   endtask

   // Index byte, often placed on the edge of the valid palette range.
   function automatic logic [7:0] pick_index();
      if ($urandom_range(0, 9) < 3)
         return 8'(sb.pal_count + 9'($urandom_range(0, 1)));
      return 8'($urandom);
   endfunction

   task automatic random_sequence();
      int         kind;
      int         n;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         send_data({1'b1, 7'($urandom)});
      end else if (kind < 48) begin
         send_data({2'b01, 6'($urandom)});
         if ($urandom_range(0, 5) == 0) send_palette(8'($urandom), $urandom);
         send_data(pick_index());
      end else if (kind < 72) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 63) : $urandom_range(1, 6);
         send_data({2'b00, 6'(n)});
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_palette(8'($urandom), $urandom);
            send_data(pick_index());
         end
      end else if (kind < 84) begin
         send_palette(8'($urandom), $urandom);
      end else if (kind < 90) begin
         send_data(8'h00);
      end else begin
         // Noise: any byte, which may cut a run short or open a new one.
         b = 8'($urandom);
         send_data(b);
      end
   endtask

   // Sender stops until every owed run has come back.
   task automatic hold_for_drain();
      push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drains and then waits out any word still inside the block.
   task automatic settle();
      hold_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, d);
   endtask

   task automatic set_config(input logic e, input logic io, input logic [31:0] bg,
                             input logic [8:0] cnt, input logic [7:0] rw);
      write_reg(srpd_pkg::CSR_EXTENDED_MODE, {31'd0, e});
      write_reg(srpd_pkg::CSR_INDEX_ONLY, {31'd0, io});
      write_reg(srpd_pkg::CSR_BACKGROUND_COLOR, bg);
      write_reg(srpd_pkg::CSR_PALETTE_COUNT, {23'd0, cnt});
      write_reg(srpd_pkg::CSR_ROW_WIDTH, {24'd0, rw});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings.
      send_palette(8'd0, 32'hffff_ffff);
      send_palette(8'd255, 32'h0000_0000);
      send_palette(8'd170, 32'ha5a5_5a5a);
      send_data(8'h80);
      send_data(8'hff);
      send_data(8'h40);
      send_data(8'h00);
      send_data(8'h7f);
      send_palette(8'd255, 32'h1234_5678);
      send_data(8'hff);
      send_data(8'h00);
      send_data(8'h03);
      send_data(8'h00);
      send_palette(8'd85, 32'h5a5a_a5a5);
      send_data(8'h55);
      send_data(8'haa);
      send_data(8'h81);
      hold_for_drain();

      // Random phases, each under its own register setting.
      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: set_config(1'b0, 1'b0, 32'hffff_ffff, 9'd256, 8'd255);
            1: set_config(1'b1, 1'b0, $urandom, 9'd256, 8'd0);
            2: set_config(1'b1, 1'b1, 32'h0000_0000, 9'd1, 8'($urandom));
            3: set_config(1'b0, 1'b1, $urandom, 9'($urandom_range(1, 256)),
                          8'($urandom_range(1, 40)));
            4: set_config(1'b1, 1'b0, $urandom, 9'($urandom_range(1, 16)),
                          8'($urandom_range(1, 20)));
            default: set_config(1'($urandom), 1'($urandom), $urandom,
                                9'($urandom_range(1, 256)), 8'($urandom));
         endcase
         target = words_sent + 105;
         while (words_sent < target) begin
            if ($urandom_range(0, 99) == 0) hold_for_drain();
            random_sequence();
         end
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
